@@ sv/atma_pkg.sv @@
package atma_pkg;

	// Field widths fixed by the sample format and the largest block.
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned SUM_W    = 18;
	localparam int unsigned CHAN_W   = 3;

	// Defaults for the top-level parameters.
	localparam int unsigned CHANNELS_DEF      = 2;
	localparam int unsigned BLOCK_SAMPLES_DEF = 16;

	localparam logic [SAMPLE_W-1:0] MIN_RESET       = 12'hFFF;
	localparam logic [SAMPLE_W-1:0] MAX_RESET       = 12'h000;
	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'h100;

	// One accumulator entry: running sum, minimum and maximum of a channel.
	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] min;
		logic [SAMPLE_W-1:0] max;
	} acc_t;

	localparam acc_t ACC_CLEAR = '{sum: '0, min: MIN_RESET, max: MAX_RESET};

endpackage

@@ sv/atma_acc.sv @@
module atma_acc #(
	parameter int unsigned CHANNELS = atma_pkg::CHANNELS_DEF,
	localparam int unsigned ADDR_W  = $clog2(CHANNELS) + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd_vld,
	input  logic [ADDR_W-1:0]             upd_addr,
	input  logic                          upd_first,
	input  logic [atma_pkg::SAMPLE_W-1:0] upd_sample,
	input  logic                          rd_en,
	input  logic [ADDR_W-1:0]             rd_addr,
	output atma_pkg::acc_t                rd_data
);

	localparam int unsigned DEPTH = 2 ** ADDR_W;

	atma_pkg::acc_t mem [DEPTH];

	logic                          vld_s1;
	logic [ADDR_W-1:0]             addr_s1;
	logic                          first_s1;
	logic [atma_pkg::SAMPLE_W-1:0] sample_s1;
	atma_pkg::acc_t                ent_s1;
	atma_pkg::acc_t                base;
	atma_pkg::acc_t                nxt;
	atma_pkg::acc_t                rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= upd_vld;
		end
	end

	// Port A: accumulate read; the write-back happens in the following cycle.
	always_ff @(posedge clk) begin
		if (upd_vld) begin
			ent_s1    <= mem[upd_addr];
			addr_s1   <= upd_addr;
			first_s1  <= upd_first;
			sample_s1 <= upd_sample;
		end
		if (vld_s1) begin
			mem[addr_s1] <= nxt;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// The first sample of a channel in a block starts from the cleared entry,
	// so the stored value of the previous use of this bank is ignored.
	always_comb begin
		base     = first_s1 ? atma_pkg::ACC_CLEAR : ent_s1;
		nxt.sum  = base.sum + atma_pkg::SUM_W'(sample_s1);
		nxt.min  = (sample_s1 < base.min) ? sample_s1 : base.min;
		nxt.max  = (sample_s1 > base.max) ? sample_s1 : base.max;
	end

	assign rd_data = rd_data_q;

	a_no_back_to_back_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		upd_vld && vld_s1 |-> upd_addr != addr_s1)
		else $error("accumulate read overlaps pending write of same entry");

	a_readout_other_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && vld_s1 |-> rd_addr != addr_s1)
		else $error("readout hits entry that is being written");

	a_entry_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !first_s1 |-> ent_s1.min <= ent_s1.max)
		else $error("accumulated entry has minimum above maximum");

endmodule

@@ sv/atma_trim_div.sv @@
module atma_trim_div #(
	parameter int unsigned CHANNELS      = atma_pkg::CHANNELS_DEF,
	parameter int unsigned BLOCK_SAMPLES = atma_pkg::BLOCK_SAMPLES_DEF,
	localparam int unsigned CH_W         = $clog2(CHANNELS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [CH_W-1:0]               in_chan,
	input  atma_pkg::acc_t                in_entry,
	output logic                          out_vld,
	output logic [CH_W-1:0]               out_chan,
	output logic [atma_pkg::SAMPLE_W-1:0] out_avg
);

	localparam int unsigned SUM_W   = atma_pkg::SUM_W;
	localparam int unsigned DIV     = BLOCK_SAMPLES - 2;
	localparam int unsigned DIV_W   = $clog2(DIV + 1);
	localparam int unsigned SHIFT   = SUM_W;
	localparam int unsigned RECIP_W = SHIFT + 1;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam int unsigned BACK_W  = SUM_W + DIV_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / DIV);
	localparam logic [DIV_W-1:0]   DIV_V = DIV_W'(DIV);

	logic [atma_pkg::SAMPLE_W:0] trim;
	logic [SUM_W-1:0]            trim_x;
	logic [SUM_W-1:0]            rest;
	logic [PROD_W-1:0]           prod;
	logic [BACK_W-1:0]           back;
	logic [SUM_W-1:0]            rem;
	logic [SUM_W-1:0]            quo;

	logic                          vld_s1, vld_s2, vld_s3;
	logic [CH_W-1:0]               chan_s1, chan_s2, chan_s3;
	logic [SUM_W-1:0]              rest_s1, rest_s2;
	logic [SUM_W-1:0]              q0_s2;
	logic [atma_pkg::SAMPLE_W-1:0] avg_s3;

	// Stage 1: drop the minimum and the maximum from the sum.
	assign trim   = {1'b0, in_entry.min} + {1'b0, in_entry.max};
	assign trim_x = SUM_W'(trim);
	assign rest   = (in_entry.sum >= trim_x) ? (in_entry.sum - trim_x) : '0;

	// Stage 2: quotient estimate by reciprocal; it is exact or one low.
	assign prod = PROD_W'(rest_s1) * PROD_W'(RECIP);

	// Stage 3: one compare and add fixes the low estimate.
	assign back = BACK_W'(q0_s2) * BACK_W'(DIV_V);
	assign rem  = rest_s2 - back[SUM_W-1:0];
	assign quo  = q0_s2 + SUM_W'(rem >= SUM_W'(DIV_V));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		chan_s1 <= in_chan;
		rest_s1 <= rest;
		chan_s2 <= chan_s1;
		rest_s2 <= rest_s1;
		q0_s2   <= prod[SHIFT +: SUM_W];
		chan_s3 <= chan_s2;
		avg_s3  <= quo[atma_pkg::SAMPLE_W-1:0];
	end

	assign out_vld  = vld_s3;
	assign out_chan = chan_s3;
	assign out_avg  = avg_s3;

endmodule

@@ sv/adc_trimmed_mean_averager_top.sv @@
// A sample is added into its channel's accumulator in the cycle after its beat is accepted.
// After the last sample of a block, the sequencer waits, reads the bank through the divider
// and drains it; then the CHANNELS results leave one per cycle unless the output stalls.
// Throughput: one sample per cycle; the last sample of a block is held off while the results
// of the previous block are still in readout.
// Reset: arst_n clears control state and sets the threshold to 256; the memory is not cleared.
module adc_trimmed_mean_averager_top #(
	parameter int unsigned CHANNELS      = atma_pkg::CHANNELS_DEF,
	parameter int unsigned BLOCK_SAMPLES = atma_pkg::BLOCK_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [atma_pkg::SAMPLE_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [atma_pkg::SAMPLE_W-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [atma_pkg::CHAN_W-1:0]   channel,
	output logic [atma_pkg::SAMPLE_W-1:0] average,
	output logic                          limit_switch,
	output logic                          last
);

	localparam int unsigned CH_W   = $clog2(CHANNELS);
	localparam int unsigned BLK_W  = $clog2(BLOCK_SAMPLES);
	localparam int unsigned ADDR_W = CH_W + 1;
	localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(CHANNELS - 1);
	localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCK_SAMPLES - 1);
	localparam logic [CH_W-1:0]  CH_FLAG  = CH_W'(1);

	// Readout sequencer. IDLE while no finished bank awaits readout; the rest walk the
	// finished bank through the divider and hand the results to the output.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WAIT  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                        state_q;
	logic [atma_pkg::SAMPLE_W-1:0] thr_q;

	// Position within the block: channel of the next sample and how many
	// samples that channel has already seen in this block.
	logic [CH_W-1:0]  chan_q;
	logic [BLK_W-1:0] blk_q;

	// The memory holds two banks of accumulators. Samples go into bank_q
	// while the bank of the block just finished, rbank_q, is read out.
	logic bank_q;
	logic rbank_q;

	logic [CH_W-1:0]               rd_idx_q;
	logic                          rd_vld_q;
	logic [CH_W-1:0]               rd_chan_q;
	logic [CH_W-1:0]               emit_idx_q;
	logic [atma_pkg::SAMPLE_W-1:0] res_q [CHANNELS];

	logic                          out_valid_q;
	logic [atma_pkg::CHAN_W-1:0]   channel_q;
	logic [atma_pkg::SAMPLE_W-1:0] average_q;
	logic                          limit_switch_q;
	logic                          last_q;

	logic                          last_beat;
	logic                          busy;
	logic                          acc_go;
	logic                          rd_en;
	logic [ADDR_W-1:0]             rd_addr;
	logic [ADDR_W-1:0]             upd_addr;
	atma_pkg::acc_t                rd_data;
	logic                          div_vld;
	logic [CH_W-1:0]               div_chan;
	logic [atma_pkg::SAMPLE_W-1:0] div_avg;
	logic                          out_load;
	logic                          flag;

	// A new block may start accumulating into the other bank at once. Only
	// the last sample of a block waits, so at most one finished block is in
	// readout and its bank is never the one being written.
	assign last_beat = (chan_q == CH_LAST) && (blk_q == BLK_LAST);
	assign busy      = (state_q != ST_IDLE);
	assign in_stall  = busy && last_beat;
	assign acc_go    = in_valid && !in_stall;
	assign upd_addr  = {bank_q, chan_q};

	assign rd_en   = (state_q == ST_READ);
	assign rd_addr = {rbank_q, rd_idx_q};

	// The output register frees its slot when its beat is taken, so the next
	// result loads in the same cycle.
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign flag     = (res_q[CH_FLAG] >= thr_q);

	atma_acc #(
		.CHANNELS (CHANNELS)
	) u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd_vld    (acc_go),
		.upd_addr   (upd_addr),
		.upd_first  (blk_q == '0),
		.upd_sample (sample),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	atma_trim_div #(
		.CHANNELS      (CHANNELS),
		.BLOCK_SAMPLES (BLOCK_SAMPLES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (rd_vld_q),
		.in_chan  (rd_chan_q),
		.in_entry (rd_data),
		.out_vld  (div_vld),
		.out_chan (div_chan),
		.out_avg  (div_avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= atma_pkg::THRESHOLD_RESET;
			chan_q      <= '0;
			blk_q       <= '0;
			bank_q      <= 1'b0;
			rbank_q     <= 1'b0;
			rd_idx_q    <= '0;
			rd_vld_q    <= 1'b0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end

			if (acc_go) begin
				if (chan_q == CH_LAST) begin
					chan_q <= '0;
					if (blk_q == BLK_LAST) begin
						blk_q   <= '0;
						bank_q  <= ~bank_q;
						rbank_q <= bank_q;
					end else begin
						blk_q <= blk_q + 1'b1;
					end
				end else begin
					chan_q <= chan_q + 1'b1;
				end
			end

			rd_vld_q <= rd_en;

			case (state_q)
				ST_IDLE: begin
					if (acc_go && last_beat) begin
						state_q <= ST_WAIT;
					end
				end
				// The WAIT state lets the write-back of the block's last sample land
				// before its entry is read.
				ST_WAIT: begin
					state_q  <= ST_READ;
					rd_idx_q <= '0;
				end
				ST_READ: begin
					if (rd_idx_q == CH_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (div_vld && (div_chan == CH_LAST)) begin
						state_q    <= ST_EMIT;
						emit_idx_q <= '0;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (emit_idx_q == CH_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_chan_q <= rd_idx_q;
		if (div_vld) begin
			res_q[div_chan] <= div_avg;
		end
		if (out_load) begin
			channel_q      <= atma_pkg::CHAN_W'(emit_idx_q);
			average_q      <= res_q[emit_idx_q];
			limit_switch_q <= flag;
			last_q         <= (emit_idx_q == CH_LAST);
		end
	end

	assign out_valid    = out_valid_q;
	assign channel      = channel_q;
	assign average      = average_q;
	assign limit_switch = limit_switch_q;
	assign last         = last_q;

endmodule
